// ===== rtl/core/ampdu_agg_pkg.sv =====
// ----------------------------------------------------------------------------
// A-MPDU aggregation selector package
// Item types, configuration register layout and register indexes.
// ----------------------------------------------------------------------------
package ampdu_agg_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SUBFRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_AGG_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_AGG_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REQUIRE_QOS   = 2'd3;

  typedef struct packed {
    logic        is_data_frame;
    logic        is_qos_data;
    logic [3:0]  traffic_id;
    logic [15:0] body_bytes;
    logic        last_in_queue;
  } frame_t;

  typedef struct packed {
    logic        frame_taken;
    logic        decision_valid;
    logic        aggregate_ok;
    logic [6:0]  taken_count;
    logic [15:0] taken_bytes;
  } result_t;

  typedef struct packed {
    logic signed [7:0]  min_subframes;
    logic signed [16:0] min_aggregate_bytes;
    logic        [15:0] max_aggregate_bytes;
    logic               require_qos;
  } cfg_t;

  // -1, -1, 4065, QoS required
  localparam cfg_t CFG_RESET = '{
    min_subframes:       8'shFF,
    min_aggregate_bytes: 17'h1FFFF,
    max_aggregate_bytes: 16'd4065,
    require_qos:         1'b1
  };

endpackage

// ===== rtl/core/ampdu_agg_cfg.sv =====
// ----------------------------------------------------------------------------
// A-MPDU aggregation configuration registers
// Holds the thresholds and the QoS switch written through the write port.
// ----------------------------------------------------------------------------
module ampdu_agg_cfg (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   wr_en,
  input  logic [ampdu_agg_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [ampdu_agg_pkg::CFG_DATA_W-1:0]   wr_data,
  output ampdu_agg_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= ampdu_agg_pkg::CFG_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        ampdu_agg_pkg::REG_MIN_SUBFRAMES: cfg.min_subframes       <= wr_data[7:0];
        ampdu_agg_pkg::REG_MIN_AGG_BYTES: cfg.min_aggregate_bytes <= wr_data[16:0];
        ampdu_agg_pkg::REG_MAX_AGG_BYTES: cfg.max_aggregate_bytes <= wr_data[15:0];
        ampdu_agg_pkg::REG_REQUIRE_QOS:   cfg.require_qos         <= wr_data[0];
      endcase
    end
  end

endmodule

// ===== rtl/core/ampdu_agg_eval.sv =====
// ----------------------------------------------------------------------------
// A-MPDU aggregation evaluator
// Holds the running aggregate state and scores one frame per advance.
// ----------------------------------------------------------------------------
module ampdu_agg_eval #(
  parameter int MAX_FRAMES         = 64,
  parameter int SUBFRAME_HDR_BYTES = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  ampdu_agg_pkg::frame_t  item,
  input  ampdu_agg_pkg::cfg_t    cfg,
  output ampdu_agg_pkg::result_t res
);

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
  localparam int SUM_W = 18;

  logic [15:0]      running_bytes, running_bytes_next;
  logic [CNT_W-1:0] frame_total, frame_total_next;
  logic [3:0]       lead_tid, lead_tid_next;
  logic             have_lead, have_lead_next;
  logic             halted, halted_next;

  logic [SUM_W-1:0] sum;
  logic             eligible;
  logic             taken;
  logic [15:0]      bytes_upd;
  logic [CNT_W-1:0] total_upd;
  logic             count_ok;
  logic             bytes_ok;

  always_comb begin
    sum = SUM_W'(running_bytes) + SUM_W'(item.body_bytes) + SUM_W'(SUBFRAME_HDR_BYTES);
    eligible = item.is_data_frame
             && !(cfg.require_qos && !item.is_qos_data)
             && (sum <= SUM_W'(cfg.max_aggregate_bytes))
             && !(have_lead && (item.traffic_id != lead_tid))
             && (frame_total < CNT_W'(MAX_FRAMES));
    taken     = !halted && eligible;
    bytes_upd = taken ? sum[15:0] : running_bytes;
    total_upd = taken ? frame_total + CNT_W'(1) : frame_total;

    // negative thresholds are always met
    count_ok = cfg.min_subframes[7]
            || (CMP_W'(cfg.min_subframes[6:0]) <= CMP_W'(total_upd));
    bytes_ok = cfg.min_aggregate_bytes[16]
            || (cfg.min_aggregate_bytes[15:0] <= bytes_upd);

    res.frame_taken    = taken;
    res.decision_valid = item.last_in_queue;
    res.aggregate_ok   = item.last_in_queue && (total_upd >= CNT_W'(2)) && count_ok && bytes_ok;
    res.taken_count    = 7'(total_upd);
    res.taken_bytes    = bytes_upd;

    if (item.last_in_queue) begin
      running_bytes_next = '0;
      frame_total_next   = '0;
      lead_tid_next      = '0;
      have_lead_next     = 1'b0;
      halted_next        = 1'b0;
    end else begin
      running_bytes_next = bytes_upd;
      frame_total_next   = total_upd;
      lead_tid_next      = (taken && !have_lead) ? item.traffic_id : lead_tid;
      have_lead_next     = have_lead || taken;
      halted_next        = halted || !eligible;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_bytes <= '0;
      frame_total   <= '0;
      lead_tid      <= '0;
      have_lead     <= 1'b0;
      halted        <= 1'b0;
    end else if (advance) begin
      running_bytes <= running_bytes_next;
      frame_total   <= frame_total_next;
      lead_tid      <= lead_tid_next;
      have_lead     <= have_lead_next;
      halted        <= halted_next;
    end
  end

endmodule

// ===== rtl/core/ampdu_aggregation_selector.sv =====
// ----------------------------------------------------------------------------
// A-MPDU aggregation selector
// Scans queued frame descriptors and decides whether they can form an A-MPDU.
// ----------------------------------------------------------------------------
// Path: an accepted frame passes the input register, then the result register.
// Throughput: one frame per cycle while the result channel is not stalled;
//   the single add-and-compare in the evaluator sets the pace.
// Reset: synchronous; clears both stages, the aggregate state and loads the
//   register defaults (thresholds off, 4065-byte maximum, QoS required).
module ampdu_aggregation_selector #(
  parameter int MAX_FRAMES         = 64,
  parameter int SUBFRAME_HDR_BYTES = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // frame descriptor channel
  input  logic                                 frame_valid,
  output logic                                 frame_stall,
  input  ampdu_agg_pkg::frame_t                frame,
  // result channel
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output ampdu_agg_pkg::result_t               result,
  // configuration write port
  input  logic                                 wr_en,
  input  logic [ampdu_agg_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [ampdu_agg_pkg::CFG_DATA_W-1:0] wr_data
);

  ampdu_agg_pkg::cfg_t    cfg;
  ampdu_agg_pkg::frame_t  frame_q;
  ampdu_agg_pkg::result_t res;
  logic                   frame_q_valid;
  logic                   out_load;
  logic                   advance;
  logic                   accept;

  ampdu_agg_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // The result register may load when it is empty or being taken; the held
  // item advances into it, which is also when the aggregate state moves on.
  assign out_load    = !result_valid || !result_stall;
  assign advance     = frame_q_valid && out_load;
  // Stall only when the input register is full and cannot advance: an item
  // is still accepted while a finished result waits downstream.
  assign frame_stall = frame_q_valid && !out_load;
  assign accept      = frame_valid && !frame_stall;

  ampdu_agg_eval #(
    .MAX_FRAMES         (MAX_FRAMES),
    .SUBFRAME_HDR_BYTES (SUBFRAME_HDR_BYTES)
  ) u_eval (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (frame_q),
    .cfg     (cfg),
    .res     (res)
  );

  // Input register: hold the item until the evaluator consumes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_q_valid <= 1'b0;
    end else if (accept) begin
      frame_q_valid <= 1'b1;
    end else if (advance) begin
      frame_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frame_q <= frame;
    end
  end

  // Result register: capture the scored item, hold it while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= frame_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

endmodule

// ===== rtl/core/ampdu_agg_chk.sv =====
// ----------------------------------------------------------------------------
// A-MPDU aggregation checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module ampdu_agg_chk (
  input logic                   clk,
  input logic                   rst,
  input logic                   result_valid,
  input logic                   result_stall,
  input ampdu_agg_pkg::result_t result
);

  logic stopped;
  logic res_accept;

  assign res_accept = result_valid && !result_stall;

  // track a stopped collection: set by a refused frame, cleared by a decision
  always_ff @(posedge clk) begin
    if (rst) begin
      stopped <= 1'b0;
    end else if (res_accept) begin
      if (result.decision_valid) begin
        stopped <= 1'b0;
      end else if (!result.frame_taken) begin
        stopped <= 1'b1;
      end
    end
  end

  a_ok_needs_decision: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.decision_valid |-> !result.aggregate_ok)
    else $error("aggregate_ok raised without a decision");

  a_no_take_after_stop: assert property (@(posedge clk) disable iff (rst)
    result_valid && stopped |-> !result.frame_taken)
    else $error("frame taken after the collection stopped");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid straight after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

endmodule

bind ampdu_aggregation_selector ampdu_agg_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
